FILE: rtl/lseg_pkg.sv
// Package for the LED strip effect generator: effect modes, the frame command
// that runs from the front part to the back part, and HSV-to-RGB helpers.
// No dependencies.
`timescale 1ns / 1ps

package lseg_pkg;

  // Effect modes. The spare two-bit code is treated as the chooser.
  typedef enum logic [1:0] {
    MODE_RAINBOW = 2'd0,
    MODE_BREATH  = 2'd1,
    MODE_CHOOSER = 2'd2
  } mode_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_CALC = 2'd1,
    BK_EMIT = 2'd2
  } back_state_t;

  // One frame of work, built by the front part for the back part.
  typedef struct packed {
    mode_t      mode;
    logic [7:0] hue;
    logic [7:0] value;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } frame_cmd_t;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] RAINBOW_TICK_INIT = 8'd1;
  localparam logic [7:0] FULL_LEVEL        = 8'd255;
  localparam logic [7:0] HUE_SECTOR        = 8'd43;
  localparam logic [7:0] HUE_REM_SCALE     = 8'd6;

  // Hue sector, the same as hue / 43 for an 8-bit hue.
  function automatic logic [2:0] hue_region(logic [7:0] h);
    logic [2:0] r;
    begin
      if (h < HUE_SECTOR) begin
        r = 3'd0;
      end else if (h < 8'(2 * HUE_SECTOR)) begin
        r = 3'd1;
      end else if (h < 8'(3 * HUE_SECTOR)) begin
        r = 3'd2;
      end else if (h < 8'(4 * HUE_SECTOR)) begin
        r = 3'd3;
      end else if (h < 8'(5 * HUE_SECTOR)) begin
        r = 3'd4;
      end else begin
        r = 3'd5;
      end
      return r;
    end
  endfunction

  // Position inside the sector, scaled by six (at most 252).
  function automatic logic [7:0] hue_rem(logic [7:0] h, logic [2:0] region);
    logic [7:0] base;
    logic [7:0] diff;
    begin
      base = 8'(region * HUE_SECTOR);
      diff = h - base;
      return 8'(diff * HUE_REM_SCALE);
    end
  endfunction

  // (255 * x) >> 8, which is x - 1 for nonzero x and 0 otherwise.
  function automatic logic [7:0] scale_255(logic [7:0] x);
    begin
      return (x == 8'd0) ? 8'd0 : x - 8'd1;
    end
  endfunction

endpackage

FILE: rtl/lseg_tick_if.sv
// Input channel of the LED strip effect generator: one frame tick word
// carrying the button levels. Depends on nothing.
`timescale 1ns / 1ps

interface lseg_tick_if;
  logic valid;
  logic ready;
  logic mode_button;
  logic red_button;
  logic green_button;
  logic blue_button;
  logic clear_button;

  modport source (
    output valid, mode_button, red_button, green_button, blue_button, clear_button,
    input  ready
  );

  modport sink (
    input  valid, mode_button, red_button, green_button, blue_button, clear_button,
    output ready
  );
endinterface

FILE: rtl/lseg_pixel_if.sv
// Output channel of the LED strip effect generator: one RGB pixel word.
// Depends on nothing.
`timescale 1ns / 1ps

interface lseg_pixel_if;
  logic       valid;
  logic       ready;
  logic [5:0] pixel_index;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic       last_pixel;

  modport source (
    output valid, pixel_index, red_level, green_level, blue_level, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_index, red_level, green_level, blue_level, last_pixel,
    output ready
  );
endinterface

FILE: rtl/lseg_front.sv
// Front part: accepts tick words, tracks the mode button and updates the
// effect state, then pushes one frame command. Uses lseg_pkg, lseg_tick_if.
`timescale 1ns / 1ps

module lseg_front (
  input  logic                clk,
  input  logic                rst,
  lseg_tick_if.sink           tick,
  input  logic                full,
  output logic                push,
  output lseg_pkg::frame_cmd_t push_data
);

  lseg_pkg::mode_t mode_index, mode_index_next;
  logic            mode_button_held, mode_button_held_next;
  logic [7:0]      rainbow_tick, rainbow_tick_next;
  logic [7:0]      breath_level, breath_level_next;
  logic [7:0]      breath_hue, breath_hue_next;
  logic            breath_falling, breath_falling_next;
  logic [7:0]      chosen_red, chosen_red_next;
  logic [7:0]      chosen_green, chosen_green_next;
  logic [7:0]      chosen_blue, chosen_blue_next;
  lseg_pkg::mode_t mode_now;

  // A word is taken whenever the queue has room.
  assign tick.ready = !full;
  assign push       = tick.valid && !full;

  // Mode button edge detection; the new mode applies to this same tick.
  always_comb begin
    mode_now              = mode_index;
    mode_button_held_next = mode_button_held;
    if (tick.mode_button && !mode_button_held) begin
      mode_button_held_next = 1'b1;
      unique case (mode_index)
        lseg_pkg::MODE_RAINBOW: mode_now = lseg_pkg::MODE_BREATH;
        lseg_pkg::MODE_BREATH:  mode_now = lseg_pkg::MODE_CHOOSER;
        default:                mode_now = lseg_pkg::MODE_RAINBOW;
      endcase
    end else if (!tick.mode_button) begin
      mode_button_held_next = 1'b0;
    end
    mode_index_next = mode_now;
  end

  // Effect state update for the current mode.
  always_comb begin
    rainbow_tick_next   = rainbow_tick;
    breath_level_next   = breath_level;
    breath_hue_next     = breath_hue;
    breath_falling_next = breath_falling;
    chosen_red_next     = chosen_red;
    chosen_green_next   = chosen_green;
    chosen_blue_next    = chosen_blue;
    unique case (mode_now)
      lseg_pkg::MODE_RAINBOW: begin
        rainbow_tick_next = rainbow_tick + 8'd1;
      end
      lseg_pkg::MODE_BREATH: begin
        if (!breath_falling) begin
          breath_level_next = breath_level + 8'd1;
          if (breath_level_next == lseg_pkg::FULL_LEVEL) begin
            breath_falling_next = 1'b1;
          end
        end else begin
          breath_level_next = breath_level - 8'd1;
          if (breath_level_next == 8'd0) begin
            breath_falling_next = 1'b0;
          end
        end
        breath_hue_next = breath_hue + 8'd1;
      end
      default: begin
        priority if (tick.red_button) begin
          chosen_red_next = chosen_red + 8'd1;
        end else if (tick.green_button) begin
          chosen_green_next = chosen_green + 8'd1;
        end else if (tick.blue_button) begin
          chosen_blue_next = chosen_blue + 8'd1;
        end else if (tick.clear_button) begin
          chosen_red_next   = 8'd0;
          chosen_green_next = 8'd0;
          chosen_blue_next  = 8'd0;
        end
      end
    endcase
  end

  // Frame command built from the state this tick runs with.
  always_comb begin
    push_data.mode  = mode_now;
    push_data.hue   = (mode_now == lseg_pkg::MODE_RAINBOW) ? rainbow_tick : breath_hue_next;
    push_data.value = (mode_now == lseg_pkg::MODE_RAINBOW) ? lseg_pkg::FULL_LEVEL
                                                           : breath_level_next;
    push_data.red   = chosen_red_next;
    push_data.green = chosen_green_next;
    push_data.blue  = chosen_blue_next;
  end

  // State registers, updated only on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_index       <= lseg_pkg::MODE_RAINBOW;
      mode_button_held <= 1'b0;
      rainbow_tick     <= lseg_pkg::RAINBOW_TICK_INIT;
      breath_level     <= 8'd0;
      breath_hue       <= 8'd0;
      breath_falling   <= 1'b0;
      chosen_red       <= 8'd0;
      chosen_green     <= 8'd0;
      chosen_blue      <= 8'd0;
    end else if (push) begin
      mode_index       <= mode_index_next;
      mode_button_held <= mode_button_held_next;
      rainbow_tick     <= rainbow_tick_next;
      breath_level     <= breath_level_next;
      breath_hue       <= breath_hue_next;
      breath_falling   <= breath_falling_next;
      chosen_red       <= chosen_red_next;
      chosen_green     <= chosen_green_next;
      chosen_blue      <= chosen_blue_next;
    end
  end

endmodule

FILE: rtl/lseg_queue.sv
// Short queue of frame commands between the front and back parts.
// Uses lseg_pkg.
`timescale 1ns / 1ps

module lseg_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lseg_pkg::frame_cmd_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output lseg_pkg::frame_cmd_t head_data
);

  localparam int PtrW = (lseg_pkg::QUEUE_DEPTH > 1) ? $clog2(lseg_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(lseg_pkg::QUEUE_DEPTH + 1);

  lseg_pkg::frame_cmd_t entries [lseg_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr, rd_ptr;
  logic [CntW-1:0]      count;
  logic                 do_push, do_pop;

  assign full       = (count == CntW'(lseg_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(lseg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(lseg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lseg_back.sv
// Back part: takes frame commands and emits one pixel word per LED, with a
// two-step HSV-to-RGB path and an output register. Uses lseg_pkg, lseg_pixel_if.
`timescale 1ns / 1ps

module lseg_back #(
  parameter int LED_COUNT = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  lseg_pkg::frame_cmd_t head_data,
  output logic                 pop,
  lseg_pixel_if.source         pixel
);

  lseg_pkg::back_state_t state, state_next;
  lseg_pkg::frame_cmd_t  cmd;
  logic [5:0]            idx;
  logic                  slot_free;
  logic                  calc_en, emit_en, idx_last;

  // Per-pixel conversion registers.
  logic [2:0]  region;
  logic [7:0]  val;
  logic [7:0]  q_lvl, t_lvl;

  // Conversion inputs for the current pixel.
  logic [7:0]  hue_c, val_c, rem_c;
  logic [2:0]  region_c;
  logic [15:0] q_prod, t_prod;

  // Colors of the current pixel before the output register.
  logic [7:0]  red_c, green_c, blue_c;

  assign slot_free = !pixel.valid || pixel.ready;
  assign idx_last  = (idx == 6'(LED_COUNT - 1));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lseg_pkg::BK_IDLE: if (head_valid) state_next = lseg_pkg::BK_CALC;
      lseg_pkg::BK_CALC: state_next = lseg_pkg::BK_EMIT;
      lseg_pkg::BK_EMIT: begin
        if (slot_free) begin
          state_next = idx_last ? lseg_pkg::BK_IDLE : lseg_pkg::BK_CALC;
        end
      end
      default: state_next = lseg_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop     = 1'b0;
    calc_en = 1'b0;
    emit_en = 1'b0;
    unique case (state)
      lseg_pkg::BK_IDLE: pop = head_valid;
      lseg_pkg::BK_CALC: calc_en = 1'b1;
      lseg_pkg::BK_EMIT: emit_en = slot_free;
      default: ;
    endcase
  end

  // First step: sector, remainder and the two products.
  always_comb begin
    hue_c    = (cmd.mode == lseg_pkg::MODE_RAINBOW) ? cmd.hue + {1'b0, idx, 1'b0} : cmd.hue;
    val_c    = cmd.value;
    region_c = lseg_pkg::hue_region(hue_c);
    rem_c    = lseg_pkg::hue_rem(hue_c, region_c);
    q_prod   = val_c * (lseg_pkg::FULL_LEVEL - lseg_pkg::scale_255(rem_c));
    t_prod   = val_c * (lseg_pkg::FULL_LEVEL
                        - lseg_pkg::scale_255(lseg_pkg::FULL_LEVEL - rem_c));
  end

  // Second step: pick the channels by sector, then apply the mode.
  always_comb begin
    unique case (region)
      3'd0: begin red_c = val;   green_c = t_lvl; blue_c = 8'd0;  end
      3'd1: begin red_c = q_lvl; green_c = val;   blue_c = 8'd0;  end
      3'd2: begin red_c = 8'd0;  green_c = val;   blue_c = t_lvl; end
      3'd3: begin red_c = 8'd0;  green_c = q_lvl; blue_c = val;   end
      3'd4: begin red_c = t_lvl; green_c = 8'd0;  blue_c = val;   end
      default: begin red_c = val; green_c = 8'd0; blue_c = q_lvl; end
    endcase
    unique case (cmd.mode)
      lseg_pkg::MODE_RAINBOW: begin
        red_c   = red_c >> 1;
        green_c = green_c >> 1;
        blue_c  = blue_c >> 1;
      end
      lseg_pkg::MODE_BREATH: ;
      default: begin
        red_c   = cmd.red;
        green_c = cmd.green;
        blue_c  = cmd.blue;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lseg_pkg::BK_IDLE;
      pixel.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_en) begin
        pixel.valid <= 1'b1;
      end else if (pixel.ready) begin
        pixel.valid <= 1'b0;
      end
    end
  end

  // Command, pixel counter and datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head_data;
      idx <= 6'd0;
    end else if (emit_en) begin
      idx <= idx + 6'd1;
    end
    if (calc_en) begin
      region <= region_c;
      val    <= val_c;
      q_lvl  <= q_prod[15:8];
      t_lvl  <= t_prod[15:8];
    end
    if (emit_en) begin
      pixel.pixel_index <= idx;
      pixel.red_level   <= red_c;
      pixel.green_level <= green_c;
      pixel.blue_level  <= blue_c;
      pixel.last_pixel  <= idx_last;
    end
  end

endmodule

FILE: rtl/led_strip_effect_generator.sv
// LED strip effect generator top level. When the back part is idle, a tick word
// is queued, popped into the command register, converted, then emitted. Each pixel
// is converted, then emitted once the output slot is free; after the last pixel the
// back part goes idle to take the next command, while the queue still takes ticks.
// Reset: rst clears the mode, effect state, queue and output valid at once.
// Uses lseg_pkg, lseg_tick_if, lseg_pixel_if, lseg_front, lseg_queue, lseg_back.
`timescale 1ns / 1ps

module led_strip_effect_generator #(
  parameter int LED_COUNT = 10
) (
  input  logic          clk,
  input  logic          rst,
  lseg_tick_if.sink     tick,
  lseg_pixel_if.source  pixel
);

  logic                 push, full, pop, head_valid;
  lseg_pkg::frame_cmd_t push_data, head_data;

  lseg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  lseg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  lseg_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .pixel      (pixel)
  );

endmodule

FILE: sim/led_strip_effect_generator_tb.sv
// Self-checking testbench for the LED strip effect generator: drives frame tick
// words, predicts every pixel word and compares them as they leave the block.
// Depends on lseg_pkg, lseg_tick_if, lseg_pixel_if and led_strip_effect_generator.
`timescale 1ns / 1ps

module led_strip_effect_generator_tb;

  localparam int LED_COUNT     = 10;
  localparam int RANDOM_ITEMS  = 210;
  localparam int LONG_HOLD     = 300;
  // Slowest frame: ten pixels, each behind a receiver stall; about 230 frames.
  localparam int CYCLE_LIMIT   = 1000000;

  // One tick word as the sender sees it; bit order matches the table below.
  typedef struct packed {
    logic mode_b;
    logic red_b;
    logic green_b;
    logic blue_b;
    logic clear_b;
  } tick_word_t;

  typedef struct packed {
    logic [5:0] pix_idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_last;
  } pixel_word_t;

  // A directed row may carry the color of its first pixel, typed in by hand.
  typedef struct {
    logic [4:0]  buttons;
    bit          typed;
    logic [23:0] rgb;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  lseg_tick_if  tick ();
  lseg_pixel_if pixel ();

  led_strip_effect_generator #(
    .LED_COUNT(LED_COUNT)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .tick (tick),
    .pixel(pixel)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Buttons are {mode, red, green, blue, clear}.
  directed_row_t directed_rows [20] = '{
    '{5'b00000, 1'b1, 24'h7F0300},  // rainbow right after reset
    '{5'b00000, 1'b0, 24'h000000},
    '{5'b11111, 1'b1, 24'h010000},  // press: breathing, first step up
    '{5'b10000, 1'b0, 24'h000000},  // held: no advance
    '{5'b00000, 1'b0, 24'h000000},
    '{5'b10000, 1'b1, 24'h000000},  // press: chooser, all dark
    '{5'b01000, 1'b1, 24'h010000},
    '{5'b01111, 1'b1, 24'h020000},  // red wins over the rest
    '{5'b00111, 1'b1, 24'h020100},
    '{5'b00011, 1'b1, 24'h020101},
    '{5'b00001, 1'b1, 24'h000000},  // clear
    '{5'b00000, 1'b1, 24'h000000},
    '{5'b11111, 1'b0, 24'h000000},  // press: chooser wraps to rainbow
    '{5'b10000, 1'b0, 24'h000000},
    '{5'b00000, 1'b0, 24'h000000},
    '{5'b10001, 1'b0, 24'h000000},
    '{5'b00100, 1'b0, 24'h000000},
    '{5'b10000, 1'b1, 24'h000000},
    '{5'b00100, 1'b1, 24'h000100},
    '{5'b00010, 1'b1, 24'h000101}
  };

  // Predicted effect state.
  lseg_pkg::mode_t cur_mode;
  logic       mode_held;
  logic [7:0] rb_tick;
  logic [7:0] br_level;
  logic [7:0] br_hue;
  logic       br_falling;
  logic [7:0] ch_red;
  logic [7:0] ch_green;
  logic [7:0] ch_blue;

  // Corners of the behavior that the run reports on at the end.
  bit br_top_seen;
  bit br_bottom_seen;
  bit tick_wrapped;
  bit chan_wrapped;

  pixel_word_t pending_pixels [$];

  int  errors;
  int  ticks_sent;
  int  pixels_seen;
  int  cycle_count;
  bit  hold_pixels_req;

  // 8-bit HSV-to-RGB at full saturation, packed as {r, g, b}.
  function automatic logic [23:0] hue_color(input logic [7:0] hue, input logic [7:0] level);
    int v;
    int sector;
    int offs;
    int falling;
    int rising;
    v       = int'(level);
    sector  = int'(hue) / int'(lseg_pkg::HUE_SECTOR);
    offs    = (int'(hue) - sector * int'(lseg_pkg::HUE_SECTOR)) * int'(lseg_pkg::HUE_REM_SCALE);
    falling = (v * (255 - ((255 * offs) >> 8))) >> 8;
    rising  = (v * (255 - ((255 * (255 - offs)) >> 8))) >> 8;
    case (sector)
      0: return {8'(v), 8'(rising), 8'd0};
      1: return {8'(falling), 8'(v), 8'd0};
      2: return {8'd0, 8'(v), 8'(rising)};
      3: return {8'd0, 8'(falling), 8'(v)};
      4: return {8'(rising), 8'd0, 8'(v)};
      default: return {8'(v), 8'd0, 8'(falling)};
    endcase
  endfunction

  task automatic reset_effect_state();
    cur_mode   = lseg_pkg::MODE_RAINBOW;
    mode_held  = 1'b0;
    rb_tick    = lseg_pkg::RAINBOW_TICK_INIT;
    br_level   = 8'd0;
    br_hue     = 8'd0;
    br_falling = 1'b0;
    ch_red     = 8'd0;
    ch_green   = 8'd0;
    ch_blue    = 8'd0;
  endtask

  // Runs one frame of the effect and queues the pixel words it must produce.
  // A typed color replaces the predicted one on the first pixel.
  task automatic run_frame_effect(input tick_word_t w, input bit typed,
                                  input logic [23:0] typed_rgb);
    logic [23:0] rgb;
    pixel_word_t px;
    if (w.mode_b && !mode_held) begin
      mode_held = 1'b1;
      case (cur_mode)
        lseg_pkg::MODE_RAINBOW: cur_mode = lseg_pkg::MODE_BREATH;
        lseg_pkg::MODE_BREATH:  cur_mode = lseg_pkg::MODE_CHOOSER;
        default:                cur_mode = lseg_pkg::MODE_RAINBOW;
      endcase
    end else if (!w.mode_b) begin
      mode_held = 1'b0;
    end

    // Frame-wide color for the two modes that light every pixel alike.
    rgb = '0;
    if (cur_mode == lseg_pkg::MODE_BREATH) begin
      if (!br_falling) begin
        br_level = br_level + 8'd1;
        if (br_level == lseg_pkg::FULL_LEVEL) begin
          br_falling  = 1'b1;
          br_top_seen = 1'b1;
        end
      end else begin
        br_level = br_level - 8'd1;
        if (br_level == 8'd0) begin
          br_falling     = 1'b0;
          br_bottom_seen = 1'b1;
        end
      end
      br_hue = br_hue + 8'd1;
      rgb    = hue_color(br_hue, br_level);
    end else if (cur_mode != lseg_pkg::MODE_RAINBOW) begin
      if (w.red_b) begin
        ch_red = ch_red + 8'd1;
        if (ch_red == 8'd0) chan_wrapped = 1'b1;
      end else if (w.green_b) begin
        ch_green = ch_green + 8'd1;
        if (ch_green == 8'd0) chan_wrapped = 1'b1;
      end else if (w.blue_b) begin
        ch_blue = ch_blue + 8'd1;
        if (ch_blue == 8'd0) chan_wrapped = 1'b1;
      end else if (w.clear_b) begin
        ch_red   = 8'd0;
        ch_green = 8'd0;
        ch_blue  = 8'd0;
      end
      rgb = {ch_red, ch_green, ch_blue};
    end

    for (int i = 0; i < LED_COUNT; i++) begin
      if (cur_mode == lseg_pkg::MODE_RAINBOW) begin
        rgb = hue_color(rb_tick + 8'(2 * i), lseg_pkg::FULL_LEVEL);
        // Each channel is halved.
        rgb = {1'b0, rgb[23:17], 1'b0, rgb[15:9], 1'b0, rgb[7:1]};
      end
      px.pix_idx = 6'(i);
      {px.red, px.green, px.blue} = (typed && i == 0) ? typed_rgb : rgb;
      px.is_last = (i == LED_COUNT - 1);
      pending_pixels.push_back(px);
    end
    if (cur_mode == lseg_pkg::MODE_RAINBOW) begin
      rb_tick = rb_tick + 8'd1;
      if (rb_tick == 8'd0) tick_wrapped = 1'b1;
    end
  endtask

  // Mostly clean press-and-release sequences, now and then a random word.
  function automatic tick_word_t next_random_tick();
    tick_word_t w;
    int roll;
    w    = '0;
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      w = 5'($urandom_range(0, 31));
      return w;
    end
    w.mode_b = mode_held ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 7) == 0);
    roll = $urandom_range(0, 9);
    case (roll)
      0, 1, 2: w.red_b   = 1'b1;
      3, 4:    w.green_b = 1'b1;
      5, 6:    w.blue_b  = 1'b1;
      7:       w.clear_b = 1'b1;
      8:       ;
      default: {w.red_b, w.green_b, w.blue_b, w.clear_b} = 4'($urandom_range(0, 15));
    endcase
    return w;
  endfunction

  // Gap before the next word: often none, mostly short, now and then long.
  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_tick(input tick_word_t w, input int gap, input bit typed,
                           input logic [23:0] typed_rgb);
    repeat (gap) begin
      @(negedge clk);
      tick.valid = 1'b0;
    end
    @(negedge clk);
    tick.valid        = 1'b1;
    tick.mode_button  = w.mode_b;
    tick.red_button   = w.red_b;
    tick.green_button = w.green_b;
    tick.blue_button  = w.blue_b;
    tick.clear_button = w.clear_b;
    @(posedge clk);
    while (!tick.ready) @(posedge clk);
    run_frame_effect(w, typed, typed_rgb);
    ticks_sent++;
  endtask

  // Stop offering words and wait for every predicted pixel to come out.
  task automatic pause_until_drained();
    @(negedge clk);
    tick.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Pixel receiver: random stalls in busy stretches, quiet stretches with
  // none, and one long hold-off on request.
  initial begin : pixel_receiver
    int  idle_left;
    int  hold_left;
    int  phase_left;
    bit  quiet;
    idle_left   = 0;
    hold_left   = 0;
    phase_left  = 0;
    quiet       = 1'b0;
    pixel.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        quiet      = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(50, 400);
      end else begin
        phase_left--;
      end
      if (hold_pixels_req) begin
        hold_pixels_req = 1'b0;
        hold_left       = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pixel.ready = 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        pixel.ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        idle_left   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        pixel.ready = 1'b0;
      end else begin
        pixel.ready = 1'b1;
      end
    end
  end

  // Compare each accepted pixel word with the oldest prediction.
  always @(posedge clk) begin : pixel_check
    pixel_word_t want;
    if (!rst && pixel.valid && pixel.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t ns: unexpected pixel word, index %0d rgb %0d/%0d/%0d", $time,
                 pixel.pixel_index, pixel.red_level, pixel.green_level, pixel.blue_level);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_index", want.pix_idx, pixel.pixel_index);
        check_field("red_level", want.red, pixel.red_level);
        check_field("green_level", want.green, pixel.green_level);
        check_field("blue_level", want.blue, pixel.blue_level);
        check_field("last_pixel", want.is_last, pixel.last_pixel);
        pixels_seen++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixel words still expected", cycle_count,
               pending_pixels.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    tick_word_t w;
    int         n_random;
    rst               = 1'b1;
    tick.valid        = 1'b0;
    tick.mode_button  = 1'b0;
    tick.red_button   = 1'b0;
    tick.green_button = 1'b0;
    tick.blue_button  = 1'b0;
    tick.clear_button = 1'b0;
    hold_pixels_req   = 1'b0;
    errors            = 0;
    ticks_sent        = 0;
    pixels_seen       = 0;
    cycle_count       = 0;
    br_top_seen       = 1'b0;
    br_bottom_seen    = 1'b0;
    tick_wrapped      = 1'b0;
    chan_wrapped      = 1'b0;
    reset_effect_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows: mode presses, holds, chooser priority and clear.
    foreach (directed_rows[k]) begin
      w = directed_rows[k].buttons;
      send_tick(w, $urandom_range(0, 2), directed_rows[k].typed, directed_rows[k].rgb);
    end
    pause_until_drained();

    // Random frames, opening with a long receiver hold-off so the block backs up.
    hold_pixels_req = 1'b1;
    n_random        = 0;
    while (n_random < RANDOM_ITEMS) begin
      w = next_random_tick();
      send_tick(w, sender_gap(), 1'b0, '0);
      n_random++;
      if (n_random == RANDOM_ITEMS / 2) pause_until_drained();
    end
    pause_until_drained();
    repeat (4 * LED_COUNT) @(posedge clk);

    $display("Sent %0d frame ticks (%0d directed) and checked %0d pixel words.",
             ticks_sent, $size(directed_rows), pixels_seen);
    $display("Receiver held off once; breathing top %0d, bottom %0d, tick wrap %0d, %s %0d.",
             br_top_seen, br_bottom_seen, tick_wrapped, "channel wrap", chan_wrapped);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
